### src/bsa_pkg.sv
`timescale 1ns / 1ps
package bsa_pkg;

    localparam int SLOTS  = 256;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SIZE_W = 16;
    localparam int OFS_W  = 24;
    localparam int CFG_W  = 2;

    localparam logic [1:0] OP_ALLOC_ONE = 2'd0;
    localparam logic [1:0] OP_FREE_ONE  = 2'd1;
    localparam logic [1:0] OP_ALLOC_RUN = 2'd2;
    localparam logic [1:0] OP_FREE_RUN  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEN  = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_NOT_USED = 3'd4;
    localparam logic [2:0] ST_PAST_END = 3'd5;

    localparam logic [CFG_W-1:0] CFG_ARENA_SLOTS = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SLOT_BYTES  = 2'd1;

    localparam logic [CNT_W-1:0]  ARENA_RESET = CNT_W'(SLOTS);
    localparam logic [SIZE_W-1:0] OBJ_RESET   = SIZE_W'(1);

    typedef struct packed {
        logic              vld;
        logic              hit;
        logic              ok;
        logic [CNT_W-1:0]  run;
        logic [SLOT_W-1:0] start;
    } t_token;

    typedef struct packed {
        logic              alloc;
        logic [SLOT_W-1:0] base;
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  n;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic              set;
        logic [SLOT_W-1:0] lo;
        logic [CNT_W-1:0]  len;
    } t_commit;

endpackage

### src/bsa_cell.sv
`timescale 1ns / 1ps
module bsa_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [bsa_pkg::SLOT_W-1:0] i_idx,
    input  bsa_pkg::t_cmd          i_cmd,
    input  bsa_pkg::t_commit       i_commit,
    input  bsa_pkg::t_token        i_tok,
    output bsa_pkg::t_token        o_tok
);
    import bsa_pkg::*;

    logic             r_used;
    t_token           r_tok;
    t_token           n_tok;
    logic [CNT_W:0]   w_idx;
    logic             w_active;
    logic             w_in_run;
    logic             w_in_commit;
    logic [CNT_W-1:0] w_run;

    assign w_idx       = (CNT_W + 1)'(i_idx);
    assign w_active    = w_idx < (CNT_W + 1)'(i_cmd.n);
    assign w_in_run    = (w_idx >= (CNT_W + 1)'(i_cmd.base)) &&
                         (w_idx < (CNT_W + 1)'(i_cmd.base) + (CNT_W + 1)'(i_cmd.len));
    assign w_in_commit = (w_idx >= (CNT_W + 1)'(i_commit.lo)) &&
                         (w_idx < (CNT_W + 1)'(i_commit.lo) + (CNT_W + 1)'(i_commit.len));
    assign w_run       = i_tok.run + CNT_W'(1);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && i_cmd.alloc && !i_tok.hit && w_active) begin
            if (r_used) begin
                n_tok.run = '0;
            end else begin
                n_tok.run = w_run;
                if (w_run == i_cmd.len) begin
                    n_tok.hit   = 1'b1;
                    n_tok.start = SLOT_W'(w_idx + (CNT_W + 1)'(1) - (CNT_W + 1)'(i_cmd.len));
                end
            end
        end
        if (i_tok.vld && !i_cmd.alloc && w_in_run && !r_used) begin
            n_tok.ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_commit.en && w_in_commit) begin
                r_used <= i_commit.set;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

### src/bitmap_slot_allocator_core.sv
`timescale 1ns / 1ps
// A request that fails its length or range check returns in the cycle after acceptance;
// every other request walks a token through the chain of SLOTS cells, busy high meanwhile,
// so no new request is accepted until the token leaves the last cell and the result returns.
// The result strobe is high for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) frees every slot, clears the used count and restores
// arena_slots = 256 and one byte per slot.
module bitmap_slot_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic [bsa_pkg::SLOT_W-1:0]  i_slot,
    input  logic [bsa_pkg::CNT_W-1:0]   i_run_length,
    output logic                        o_result_strobe,
    output logic [2:0]                  o_status,
    output logic [bsa_pkg::SLOT_W-1:0]  o_granted_slot,
    output logic [bsa_pkg::OFS_W-1:0]   o_byte_offset,
    output logic [bsa_pkg::CNT_W-1:0]   o_slots_used,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bsa_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [bsa_pkg::SIZE_W-1:0]  i_cfg_data
);
    import bsa_pkg::*;

    logic [CNT_W-1:0]  r_arena;
    logic [SIZE_W-1:0] r_obj_size;
    logic [CNT_W-1:0]  r_total;
    logic              r_busy;
    logic              r_inject;
    t_cmd              r_cmd;
    logic              r_strobe;
    logic [2:0]        r_status;
    logic [SLOT_W-1:0] r_grant;
    logic [OFS_W-1:0]  r_offset;
    logic [CNT_W-1:0]  r_used_out;

    t_token            w_tok [SLOTS+1];
    t_token            w_last;
    t_commit           w_commit;
    logic              w_accept;
    logic              w_alloc;
    logic [CNT_W-1:0]  w_n;
    logic [CNT_W-1:0]  w_len;
    logic [2:0]        w_check;

    assign w_accept = start && !r_busy;
    assign w_n      = (r_arena > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : r_arena;
    assign w_alloc  = (i_op == OP_ALLOC_ONE) || (i_op == OP_ALLOC_RUN);
    assign w_len    = ((i_op == OP_ALLOC_ONE) || (i_op == OP_FREE_ONE)) ?
                      CNT_W'(1) : i_run_length;

    always_comb begin
        w_check = ST_OK;
        if (w_alloc) begin
            if (w_len == '0) begin
                w_check = ST_BAD_LEN;
            end
        end else if (CNT_W'(i_slot) >= w_n) begin
            w_check = ST_RANGE;
        end else if ((CNT_W + 1)'(i_slot) + (CNT_W + 1)'(w_len) > (CNT_W + 1)'(w_n)) begin
            w_check = ST_PAST_END;
        end
    end

    assign w_tok[0] = '{vld: r_inject, hit: 1'b0, ok: 1'b1, run: '0, start: '0};
    assign w_last   = w_tok[SLOTS];

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            bsa_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_idx    (SLOT_W'(gi)),
                .i_cmd    (r_cmd),
                .i_commit (w_commit),
                .i_tok    (w_tok[gi]),
                .o_tok    (w_tok[gi+1])
            );
        end
    endgenerate

    always_comb begin
        w_commit.en  = w_last.vld && (r_cmd.alloc ? w_last.hit : w_last.ok);
        w_commit.set = r_cmd.alloc;
        w_commit.lo  = r_cmd.alloc ? w_last.start : r_cmd.base;
        w_commit.len = r_cmd.len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena    <= ARENA_RESET;
            r_obj_size <= OBJ_RESET;
            r_total    <= '0;
            r_busy     <= 1'b0;
            r_inject   <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_inject <= 1'b0;
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ARENA_SLOTS: r_arena    <= i_cfg_data[CNT_W-1:0];
                    CFG_SLOT_BYTES:  r_obj_size <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (w_check != ST_OK) begin
                    r_strobe   <= 1'b1;
                    r_status   <= w_check;
                    r_grant    <= '0;
                    r_offset   <= '0;
                    r_used_out <= r_total;
                end else begin
                    r_busy    <= 1'b1;
                    r_inject  <= 1'b1;
                    r_cmd     <= '{alloc: w_alloc, base: i_slot, len: w_len, n: w_n};
                end
            end
            if (w_last.vld) begin
                r_busy   <= 1'b0;
                r_strobe <= 1'b1;
                r_grant  <= '0;
                r_offset <= '0;
                if (r_cmd.alloc) begin
                    if (w_last.hit) begin
                        r_status   <= ST_OK;
                        r_grant    <= w_last.start;
                        r_offset   <= OFS_W'(OFS_W'(w_last.start) * OFS_W'(r_obj_size));
                        r_total    <= r_total + r_cmd.len;
                        r_used_out <= r_total + r_cmd.len;
                    end else begin
                        r_status   <= ST_NO_SPACE;
                        r_used_out <= r_total;
                    end
                end else if (w_last.ok) begin
                    r_status   <= ST_OK;
                    r_total    <= (r_total >= r_cmd.len) ? r_total - r_cmd.len : '0;
                    r_used_out <= (r_total >= r_cmd.len) ? r_total - r_cmd.len : '0;
                end else begin
                    r_status   <= ST_NOT_USED;
                    r_used_out <= r_total;
                end
            end
        end
    end

    assign busy            = r_busy;
    assign o_cfg_ready     = !r_busy;
    assign o_result_strobe = r_strobe;
    assign o_status        = r_status;
    assign o_granted_slot  = r_grant;
    assign o_byte_offset   = r_offset;
    assign o_slots_used    = r_used_out;

endmodule

### src/bsa_checker.sv
`timescale 1ns / 1ps
module bsa_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        o_result_strobe,
    input  logic [2:0]                  o_status,
    input  logic [bsa_pkg::SLOT_W-1:0]  o_granted_slot,
    input  logic [bsa_pkg::OFS_W-1:0]   o_byte_offset,
    input  logic [bsa_pkg::CNT_W-1:0]   o_slots_used
);
    import bsa_pkg::*;

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_result_strobe || busy))
        else $error("accepted request neither answered nor in progress");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_status != ST_OK) |->
        (o_granted_slot == '0 && o_byte_offset == '0))
        else $error("failed request carries a grant");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_slots_used <= CNT_W'(SLOTS)))
        else $error("used count above slot count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_strobe))
        else $error("busy or strobe after reset");

endmodule

bind bitmap_slot_allocator_core bsa_checker u_bsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_status        (o_status),
    .o_granted_slot  (o_granted_slot),
    .o_byte_offset   (o_byte_offset),
    .o_slots_used    (o_slots_used)
);
